[sv/sqch_pkg.sv]
// Shared types, codes and the duty pattern table for the square channel.
// Used by the top, sqch_cfg and sqch_core of the square channel block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sqch_pkg;

  // Beat codes on the input channel
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_FRAME   = 3'd1;
  localparam logic [2:0] ACT_FREQ_LO = 3'd2;
  localparam logic [2:0] ACT_CTRL    = 3'd3;
  localparam logic [2:0] ACT_LEN     = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_SWEEP_PERIOD = 3'd0;
  localparam logic [2:0] REG_SWEEP_NEGATE = 3'd1;
  localparam logic [2:0] REG_SWEEP_SHIFT  = 3'd2;
  localparam logic [2:0] REG_ENV_START    = 3'd3;
  localparam logic [2:0] REG_ENV_INC      = 3'd4;
  localparam logic [2:0] REG_ENV_PERIOD   = 3'd5;
  localparam logic [2:0] REG_DUTY_SEL     = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  // Length counter constants
  localparam logic [6:0] LEN_FULL = 7'd64;

  typedef struct packed {
    logic [2:0] sweep_period;
    logic       sweep_negate;
    logic [2:0] sweep_shift;
    logic [3:0] env_start;
    logic       env_inc;
    logic [2:0] env_period;
    logic [1:0] duty_sel;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  level;
    logic        active;
    logic        dac;
    logic [10:0] freq;
  } result_t;

  // Duty patterns, one row of eight steps per selection
  function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
    logic [7:0] row;
    case (sel)
      2'd0:    row = 8'b1000_0000;
      2'd1:    row = 8'b1000_0001;
      2'd2:    row = 8'b1110_0001;
      2'd3:    row = 8'b0111_1110;
      default: row = 8'b0000_0000;
    endcase
    // bit index equals step position
    return row[pos];
  endfunction

  function automatic logic dac_on(input cfg_t c);
    return (c.env_start != 4'd0) || c.env_inc;
  endfunction

endpackage

`default_nettype wire

[sv/square_channel_with_sweep_top.sv]
// Square channel with frequency sweep: one beat in, one result beat out.
// A beat taken into the input register passes through the state update into the result register.
// Throughput: one beat per cycle while the output is not stalled; the input register feeds the state update,
// whose result lands in the output register, so a taken result frees it at once.
// Reset (rst_n low at a clock edge) clears the channel state, the configuration and both valid flags.
// Depends on sqch_pkg, sqch_cfg, sqch_core and sqch_sweep.
`timescale 1ns / 1ps
`default_nettype none

module square_channel_with_sweep_top (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire [2:0]                       in_action,
  input  wire [7:0]                       in_write_data,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [3:0]                      out_level,
  output logic                            out_channel_active,
  output logic                            out_dac_enabled,
  output logic [10:0]                     out_current_frequency,
  input  wire                             cfg_we,
  input  wire [sqch_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [sqch_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import sqch_pkg::*;

  cfg_t    cfg;
  logic    cfg_kill;
  result_t res_nxt;
  result_t res_r;

  logic       s1_valid_r;
  logic [2:0] s1_action_r;
  logic [7:0] s1_data_r;
  logic       out_valid_r;
  logic       out_busy;
  logic       adv;
  logic       in_take;

  // Output register holds only while a result waits under stall
  assign out_busy = out_valid_r && out_stall;
  assign adv      = s1_valid_r && !out_busy;
  assign in_stall = s1_valid_r && out_busy;
  assign in_take  = in_valid && !in_stall;

  sqch_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .cfg_kill  (cfg_kill)
  );

  sqch_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .action   (s1_action_r),
    .data     (s1_data_r),
    .cfg      (cfg),
    .cfg_kill (cfg_kill),
    .res_nxt  (res_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= in_action;
      s1_data_r   <= in_write_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_busy) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_level             = res_r.level;
  assign out_channel_active    = res_r.active;
  assign out_dac_enabled       = res_r.dac;
  assign out_current_frequency = res_r.freq;

endmodule

`default_nettype wire

[sv/sqch_cfg.sv]
// Configuration register file of the square channel.
// Depends on sqch_pkg for register indexes and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module sqch_cfg (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire [sqch_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [sqch_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output sqch_pkg::cfg_t                  cfg,
  output logic                            cfg_kill
);
  import sqch_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Next register values for a write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SWEEP_PERIOD: cfg_nxt.sweep_period = cfg_wdata[2:0];
        REG_SWEEP_NEGATE: cfg_nxt.sweep_negate = cfg_wdata[0];
        REG_SWEEP_SHIFT:  cfg_nxt.sweep_shift  = cfg_wdata[2:0];
        REG_ENV_START:    cfg_nxt.env_start    = cfg_wdata;
        REG_ENV_INC:      cfg_nxt.env_inc      = cfg_wdata[0];
        REG_ENV_PERIOD:   cfg_nxt.env_period   = cfg_wdata[2:0];
        REG_DUTY_SEL:     cfg_nxt.duty_sel     = cfg_wdata[1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  // An envelope register write that leaves the DAC off stops the channel
  assign cfg_kill = cfg_we && !dac_on(cfg_nxt) &&
                    ((cfg_index == REG_ENV_START) || (cfg_index == REG_ENV_INC) ||
                     (cfg_index == REG_ENV_PERIOD));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[sv/sqch_sweep.sv]
// Sweep frequency calculator: shadow plus or minus shadow shifted right.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module sqch_sweep (
  input  wire [10:0] shadow,
  input  wire        negate,
  input  wire [2:0]  shift,
  output logic [11:0] freq,
  output logic        ovf
);

  logic [10:0] delta;

  // delta never exceeds shadow, so the subtract does not wrap
  assign delta = shadow >> shift;
  assign freq  = negate ? ({1'b0, shadow} - {1'b0, delta})
                        : ({1'b0, shadow} + {1'b0, delta});
  assign ovf   = freq[11];

endmodule

`default_nettype wire

[sv/sqch_core.sv]
// Channel state and its update for one beat: timer, duty, length, envelope,
// sweep and register writes. Depends on sqch_pkg and sqch_sweep.
`timescale 1ns / 1ps
`default_nettype none

module sqch_core (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 adv,
  input  wire [2:0]           action,
  input  wire [7:0]           data,
  input  sqch_pkg::cfg_t      cfg,
  input  wire                 cfg_kill,
  output sqch_pkg::result_t   res_nxt
);
  import sqch_pkg::*;

  logic [10:0] freq_r,   freq_nxt;
  logic [10:0] shadow_r, shadow_nxt;
  logic [13:0] period_r, period_nxt;
  logic [2:0]  duty_r,   duty_nxt;
  logic [6:0]  len_r,    len_nxt;
  logic        len_on_r, len_on_nxt;
  logic [3:0]  env_t_r,  env_t_nxt;
  logic [3:0]  vol_r,    vol_nxt;
  logic [3:0]  swt_r,    swt_nxt;
  logic        sw_act_r, sw_act_nxt;
  logic        run_r,    run_nxt;
  logic [2:0]  step_r,   step_nxt;

  logic [2:0]  step_inc;
  logic [6:0]  len_mid;
  logic [3:0]  env_reload;
  logic [3:0]  swt_reload;
  logic        dac;
  logic [10:0] trig_shadow;
  logic [11:0] swa_f, swb_f, swt_f;
  logic        swa_ovf, swb_ovf, swt_ovf;

  assign step_inc    = step_r + 3'd1;
  assign env_reload  = (cfg.env_period != 3'd0) ? {1'b0, cfg.env_period} : 4'd8;
  assign swt_reload  = (cfg.sweep_period != 3'd0) ? {1'b0, cfg.sweep_period} : 4'd8;
  assign dac         = dac_on(cfg);
  assign trig_shadow = {data[2:0], freq_r[7:0]};

  // Sweep update on the shadow, then the recheck on the new value
  sqch_sweep u_sweep_a (
    .shadow (shadow_r),
    .negate (cfg.sweep_negate),
    .shift  (cfg.sweep_shift),
    .freq   (swa_f),
    .ovf    (swa_ovf)
  );

  sqch_sweep u_sweep_b (
    .shadow (swa_f[10:0]),
    .negate (cfg.sweep_negate),
    .shift  (cfg.sweep_shift),
    .freq   (swb_f),
    .ovf    (swb_ovf)
  );

  // Overflow check at trigger time
  sqch_sweep u_sweep_t (
    .shadow (trig_shadow),
    .negate (cfg.sweep_negate),
    .shift  (cfg.sweep_shift),
    .freq   (swt_f),
    .ovf    (swt_ovf)
  );

  // Next state for the beat in the input register
  always_comb begin
    freq_nxt   = freq_r;
    shadow_nxt = shadow_r;
    period_nxt = period_r;
    duty_nxt   = duty_r;
    len_nxt    = len_r;
    len_on_nxt = len_on_r;
    env_t_nxt  = env_t_r;
    vol_nxt    = vol_r;
    swt_nxt    = swt_r;
    sw_act_nxt = sw_act_r;
    run_nxt    = run_r;
    step_nxt   = step_r;
    len_mid    = len_r;

    case (action)
      ACT_TICK: begin
        if (period_r <= 14'd1) begin
          period_nxt = {(12'd2048 - {1'b0, freq_r}), 2'b00};
          duty_nxt   = duty_r + 3'd1;
        end else begin
          period_nxt = period_r - 14'd1;
        end
      end

      ACT_FRAME: begin
        step_nxt = step_inc;
        // length on even steps
        if (!step_inc[0] && len_on_r && (len_r != 7'd0)) begin
          len_nxt = len_r - 7'd1;
          if (len_r == 7'd1) run_nxt = 1'b0;
        end
        // envelope on the last step
        if ((step_inc == 3'd7) && (env_t_r != 4'd0)) begin
          env_t_nxt = env_t_r - 4'd1;
          if (env_t_r == 4'd1) begin
            env_t_nxt = env_reload;
            if (cfg.env_inc && (vol_r != 4'd15)) vol_nxt = vol_r + 4'd1;
            else if (!cfg.env_inc && (vol_r != 4'd0)) vol_nxt = vol_r - 4'd1;
          end
        end
        // sweep on steps two and six
        if ((step_inc[1:0] == 2'd2) && (swt_r != 4'd0)) begin
          swt_nxt = swt_r - 4'd1;
          if (swt_r == 4'd1) begin
            swt_nxt = swt_reload;
            if (sw_act_r && (cfg.sweep_period != 3'd0)) begin
              if (swa_ovf) begin
                run_nxt = 1'b0;
              end else if (cfg.sweep_shift != 3'd0) begin
                freq_nxt   = swa_f[10:0];
                shadow_nxt = swa_f[10:0];
                if (swb_ovf) run_nxt = 1'b0;
              end
            end
          end
        end
      end

      ACT_FREQ_LO: freq_nxt = {freq_r[10:8], data};

      ACT_CTRL: begin
        if (data[7]) begin
          shadow_nxt = trig_shadow;
          swt_nxt    = swt_reload;
          sw_act_nxt = (cfg.sweep_period != 3'd0) || (cfg.sweep_shift != 3'd0);
          if (len_r == 7'd0) len_mid = LEN_FULL;
          env_t_nxt  = {1'b0, cfg.env_period};
          vol_nxt    = cfg.env_start;
          run_nxt    = dac && !((cfg.sweep_shift != 3'd0) && swt_ovf);
        end
        len_nxt = len_mid;
        // enabling length on an even step clocks it once
        if (data[6] && !len_on_r && !step_r[0] && (len_mid != 7'd0)) begin
          len_nxt = len_mid - 7'd1;
          if (len_mid == 7'd1) run_nxt = 1'b0;
        end
        len_on_nxt = data[6];
        freq_nxt   = {data[2:0], freq_r[7:0]};
      end

      ACT_LEN: len_nxt = LEN_FULL - {1'b0, data[5:0]};

      default: ;
    endcase
  end

  // Result seen after this beat
  always_comb begin
    res_nxt.level  = (run_nxt && dac && duty_bit(cfg.duty_sel, duty_nxt)) ? vol_nxt : 4'd0;
    res_nxt.active = run_nxt;
    res_nxt.dac    = dac;
    res_nxt.freq   = freq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r   <= '0;
      shadow_r <= '0;
      period_r <= '0;
      duty_r   <= '0;
      len_r    <= '0;
      len_on_r <= 1'b0;
      env_t_r  <= '0;
      vol_r    <= '0;
      swt_r    <= '0;
      sw_act_r <= 1'b0;
      run_r    <= 1'b0;
      step_r   <= '0;
    end else begin
      if (adv) begin
        freq_r   <= freq_nxt;
        shadow_r <= shadow_nxt;
        period_r <= period_nxt;
        duty_r   <= duty_nxt;
        len_r    <= len_nxt;
        len_on_r <= len_on_nxt;
        env_t_r  <= env_t_nxt;
        vol_r    <= vol_nxt;
        swt_r    <= swt_nxt;
        sw_act_r <= sw_act_nxt;
        step_r   <= step_nxt;
      end
      // register writes are to happen only while idle; the user is bound, the block itself does not enforce it
      if (cfg_kill) begin
        run_r <= 1'b0;
      end else if (adv) begin
        run_r <= run_nxt;
      end
    end
  end

  // Checks
  a_kill_stops: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_kill |=> !run_r) else $error("channel still running after DAC off");
  a_run_dac: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> dac) else $error("channel running with DAC off");
  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_FULL) else $error("length count above full");
  a_timers_max: assert property (@(posedge clk) disable iff (!rst_n)
    (swt_r <= 4'd8) && (env_t_r <= 4'd8)) else $error("sweep or envelope timer too large");

endmodule

`default_nettype wire
